// ===== hw/rtl/b64d_pkg.sv =====
// b64d_pkg: shared types for the base64 stream decoder.
// Used by b64d_front, b64d_fifo, b64d_back and base64_stream_decoder.
`timescale 1ns / 1ps

package b64d_pkg;

  // Character class decided by the front end
  typedef enum logic [1:0] {
    KIND_SYM  = 2'd0,
    KIND_SKIP = 2'd1,
    KIND_BAD  = 2'd2
  } kind_e;

  // Final status codes
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_TRUNC   = 2'd2
  } status_e;

  // Classified item handed from front to back
  typedef struct packed {
    kind_e      kind;
    logic [5:0] sextet;
    logic       last;
  } cmd_t;

endpackage

// ===== hw/rtl/b64d_front.sv =====
// b64d_front: accepts raw characters and classifies them into commands.
// Depends on b64d_pkg (cmd_t, kind_e).
`timescale 1ns / 1ps

module b64d_front (
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [7:0]      char_in_i,
  input  logic            doc_end_i,
  output logic            push_valid_o,
  input  logic            push_ready_i,
  output b64d_pkg::cmd_t  push_cmd_o
);
  import b64d_pkg::*;

  kind_e      kind;
  logic [5:0] sextet;

  // Alphabet decode: both standard and URL-safe, whitespace and '=' skipped
  always_comb begin
    kind   = KIND_BAD;
    sextet = 6'd0;
    if (char_in_i == 8'h20 || char_in_i == 8'h09 || char_in_i == 8'h0D ||
        char_in_i == 8'h0A || char_in_i == 8'h3D) begin
      kind = KIND_SKIP;
    end else if (char_in_i >= 8'h41 && char_in_i <= 8'h5A) begin
      kind   = KIND_SYM;
      sextet = 6'(char_in_i - 8'h41);
    end else if (char_in_i >= 8'h61 && char_in_i <= 8'h7A) begin
      kind   = KIND_SYM;
      sextet = 6'(char_in_i - 8'h61 + 8'd26);
    end else if (char_in_i >= 8'h30 && char_in_i <= 8'h39) begin
      kind   = KIND_SYM;
      sextet = 6'(char_in_i - 8'h30 + 8'd52);
    end else if (char_in_i == 8'h2B || char_in_i == 8'h2D) begin
      kind   = KIND_SYM;
      sextet = 6'd62;
    end else if (char_in_i == 8'h2F || char_in_i == 8'h5F) begin
      kind   = KIND_SYM;
      sextet = 6'd63;
    end
  end

  assign push_cmd_o.kind   = kind;
  assign push_cmd_o.sextet = sextet;
  assign push_cmd_o.last   = doc_end_i;
  assign push_valid_o      = in_valid_i;
  assign in_ready_o        = push_ready_i;

endmodule

// ===== hw/rtl/b64d_fifo.sv =====
// b64d_fifo: two-entry command queue between front and back.
// Depends on b64d_pkg (cmd_t).
`timescale 1ns / 1ps

module b64d_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  b64d_pkg::cmd_t  push_cmd_i,
  output logic            pop_valid_o,
  input  logic            pop_ready_i,
  output b64d_pkg::cmd_t  pop_cmd_o
);
  import b64d_pkg::*;

  cmd_t       mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       do_push, do_pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign pop_cmd_o    = mem_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  // Pointer and occupancy update
  always_comb begin
    wr_ptr_d = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop  ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 2'd1;
    end else if (!do_push && do_pop) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage, no reset
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

// ===== hw/rtl/b64d_back.sv =====
// b64d_back: executes classified commands, holds the decode state and the
// output register. Depends on b64d_pkg (cmd_t, kind_e, status_e).
`timescale 1ns / 1ps

module b64d_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            pop_valid_i,
  output logic            pop_ready_o,
  input  b64d_pkg::cmd_t  pop_cmd_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [7:0]      data_byte_o,
  output logic            is_final_o,
  output logic [1:0]      status_o
);
  import b64d_pkg::*;

  // Decode state
  logic [5:0] left_bits_q, left_bits_d;
  logic [2:0] left_cnt_q, left_cnt_d;
  logic [1:0] phase_q, phase_d;
  logic       saw_q, saw_d;
  logic       failed_q, failed_d;

  // Pending final status after a data byte on the last character
  logic       fin_pend_q, fin_pend_d;
  status_e    fin_st_q, fin_st_d;

  // Output register
  logic       out_valid_q, out_valid_d;
  logic [7:0] out_byte_q, out_byte_d;
  logic       out_final_q, out_final_d;
  status_e    out_st_q, out_st_d;

  logic        slot_free, take;
  logic [11:0] acc, mask, kept;
  logic [3:0]  cnt, cnt_adj;
  logic        has_byte;
  logic [7:0]  new_byte;
  status_e     st;

  assign slot_free   = !out_valid_q || out_ready_i;
  assign pop_ready_o = slot_free && !fin_pend_q;
  assign take        = pop_valid_i && pop_ready_o;

  // Sextet merge into the leftover bits
  always_comb begin
    acc      = {left_bits_q, pop_cmd_i.sextet};
    cnt      = 4'({1'b0, left_cnt_q}) + 4'd6;
    has_byte = (cnt >= 4'd8);
    cnt_adj  = has_byte ? cnt - 4'd8 : cnt;
    new_byte = 8'(acc >> cnt_adj);
    mask     = (12'd1 << cnt_adj) - 12'd1;
    kept     = acc & mask;
  end

  // Command execution and result sequencing
  always_comb begin
    left_bits_d = left_bits_q;
    left_cnt_d  = left_cnt_q;
    phase_d     = phase_q;
    saw_d       = saw_q;
    failed_d    = failed_q;
    fin_pend_d  = fin_pend_q;
    fin_st_d    = fin_st_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_byte_d  = out_byte_q;
    out_final_d = out_final_q;
    out_st_d    = out_st_q;
    st          = ST_OK;

    if (fin_pend_q && slot_free) begin
      out_valid_d = 1'b1;
      out_byte_d  = 8'd0;
      out_final_d = 1'b1;
      out_st_d    = fin_st_q;
      fin_pend_d  = 1'b0;
    end else if (take) begin
      if (!failed_q) begin
        if (pop_cmd_i.kind == KIND_BAD) begin
          failed_d = 1'b1;
        end else if (pop_cmd_i.kind == KIND_SYM) begin
          left_bits_d = kept[5:0];
          left_cnt_d  = cnt_adj[2:0];
          phase_d     = phase_q + 2'd1;
          saw_d       = 1'b1;
          if (has_byte) begin
            out_valid_d = 1'b1;
            out_byte_d  = new_byte;
            out_final_d = 1'b0;
            out_st_d    = ST_OK;
          end
        end
      end

      if (pop_cmd_i.last) begin
        if (failed_d) begin
          st = ST_INVALID;
        end else if (saw_d && phase_d == 2'd1) begin
          st = ST_TRUNC;
        end
        if (out_valid_d) begin
          // data byte goes first, status once the output slot is free
          fin_pend_d = 1'b1;
          fin_st_d   = st;
        end else begin
          out_valid_d = 1'b1;
          out_byte_d  = 8'd0;
          out_final_d = 1'b1;
          out_st_d    = st;
        end
        left_bits_d = 6'd0;
        left_cnt_d  = 3'd0;
        phase_d     = 2'd0;
        saw_d       = 1'b0;
        failed_d    = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_bits_q <= 6'd0;
      left_cnt_q  <= 3'd0;
      phase_q     <= 2'd0;
      saw_q       <= 1'b0;
      failed_q    <= 1'b0;
      fin_pend_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      left_bits_q <= left_bits_d;
      left_cnt_q  <= left_cnt_d;
      phase_q     <= phase_d;
      saw_q       <= saw_d;
      failed_q    <= failed_d;
      fin_pend_q  <= fin_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk_i) begin
    fin_st_q    <= fin_st_d;
    out_byte_q  <= out_byte_d;
    out_final_q <= out_final_d;
    out_st_q    <= out_st_d;
  end

  assign out_valid_o = out_valid_q;
  assign data_byte_o = out_byte_q;
  assign is_final_o  = out_final_q;
  assign status_o    = out_st_q;

endmodule

// ===== hw/rtl/base64_stream_decoder.sv =====
// base64_stream_decoder: top level of the streaming base64 decoder.
// Depends on b64d_pkg, b64d_front, b64d_fifo and b64d_back.
`timescale 1ns / 1ps

// Decodes a base64 document one character per item, standard and URL-safe
// alphabets mixed freely; space, tab, CR, LF and '=' are skipped. Each decoded
// byte leaves as a result with is_final_o low; the item flagged doc_end_i
// produces one more result with is_final_o high and status_o set to 0 (ok),
// 1 (invalid character seen) or 2 (truncated), after which the state clears.
// Throughput is one item per cycle while the output is not stalled, set by the
// back-end unit that merges one sextet and writes one result per cycle; the
// one exception is a doc_end_i character that completes a byte, which yields
// two results (byte, then status). An input is registered first in the
// two-entry command queue and then in the output register.

module base64_stream_decoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] char_in_i,
  input  logic       doc_end_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] data_byte_o,
  output logic       is_final_o,
  output logic [1:0] status_o
);
  import b64d_pkg::*;

  logic push_valid, push_ready;
  cmd_t push_cmd;
  logic pop_valid, pop_ready;
  cmd_t pop_cmd;

  b64d_front u_front (
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .char_in_i    (char_in_i),
    .doc_end_i    (doc_end_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_cmd_o   (push_cmd)
  );

  b64d_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_cmd_i   (push_cmd),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_cmd_o    (pop_cmd)
  );

  b64d_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_cmd_i   (pop_cmd),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .data_byte_o (data_byte_o),
    .is_final_o  (is_final_o),
    .status_o    (status_o)
  );

endmodule
